### rtl/core/ksfa_pkg.sv
`timescale 1ns / 1ps
package ksfa_pkg;

	localparam int POS_W      = 32;
	localparam int SPD_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_SEEK   = 2'd0,
		MODE_FLEE   = 2'd1,
		MODE_ARRIVE = 2'd2
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_RAD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TGT  = 2'd3;

	localparam logic [SPD_W-1:0] MAX_SPEED_RST = 31'd65536;
	localparam logic [SPD_W-1:0] STOP_RAD_RST  = 31'd65536;
	localparam logic [SPD_W-1:0] TIME_TGT_RST  = 31'd65536;

endpackage

### rtl/core/ksfa_if.sv
`timescale 1ns / 1ps
interface ksfa_in_if;
	import ksfa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] char_x;
	logic signed [POS_W-1:0] char_y;
	logic signed [POS_W-1:0] tgt_x;
	logic signed [POS_W-1:0] tgt_y;
	modport source (output valid, char_x, char_y, tgt_x, tgt_y, input ready);
	modport sink (input valid, char_x, char_y, tgt_x, tgt_y, output ready);
endinterface

interface ksfa_out_if;
	import ksfa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] vel_x;
	logic signed [POS_W-1:0] vel_y;
	logic                    arrived;
	modport source (output valid, vel_x, vel_y, arrived, input ready);
	modport sink (input valid, vel_x, vel_y, arrived, output ready);
endinterface

interface ksfa_cfg_if;
	import ksfa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ksfa_sqrt.sv
`timescale 1ns / 1ps
// Floor square root, one root bit per pipeline stage.
module ksfa_sqrt #(
	parameter int RAD_W = 66,
	parameter int PAY_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [RAD_W-1:0]       in_rad,
	input  logic [PAY_W-1:0]       in_pay,
	output logic                   out_valid,
	output logic [RAD_W/2-1:0]     out_root,
	output logic [PAY_W-1:0]       out_pay
);
	localparam int RT    = RAD_W / 2;
	localparam int REM_W = RT + 2;

	logic             v_s    [RT+1];
	logic [REM_W-1:0] rem_s  [RT+1];
	logic [RT-1:0]    root_s [RT+1];
	logic [RAD_W-1:0] rad_s  [RT+1];
	logic [PAY_W-1:0] pay_s  [RT+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign pay_s[0]  = in_pay;

	for (genvar i = 0; i < RT; i++) begin : g_stage
		logic [REM_W+1:0] rsh;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		logic             ge;

		assign rsh   = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
		assign trial = {2'b00, root_s[i], 2'b01};
		assign diff  = rsh - trial;
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[REM_W-1:0] : rsh[REM_W-1:0];
				root_s[i+1] <= {root_s[i][RT-2:0], ge};
				rad_s[i+1]  <= {rad_s[i][RAD_W-3:0], 2'b00};
				pay_s[i+1]  <= pay_s[i];
			end
		end
	end

	assign out_valid = v_s[RT];
	assign out_root  = root_s[RT];
	assign out_pay   = pay_s[RT];

endmodule

### rtl/core/ksfa_div.sv
`timescale 1ns / 1ps
// Restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// The starting remainder must be below the divisor.
module ksfa_div #(
	parameter int VW    = 33,
	parameter int QW    = 31,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [VW-1:0]    rem0_a,
	input  logic [VW-1:0]    rem0_b,
	input  logic [QW-1:0]    num_a,
	input  logic [QW-1:0]    num_b,
	input  logic [VW-1:0]    den,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	output logic [QW-1:0]    quo_a,
	output logic [QW-1:0]    quo_b,
	output logic [PAY_W-1:0] out_pay
);
	logic             v_s   [QW+1];
	logic [VW-1:0]    den_s [QW+1];
	logic [PAY_W-1:0] pay_s [QW+1];
	logic [VW-1:0]    rem_s [QW+1][2];
	logic [QW-1:0]    num_s [QW+1][2];

	assign v_s[0]      = in_valid;
	assign den_s[0]    = den;
	assign pay_s[0]    = in_pay;
	assign rem_s[0][0] = rem0_a;
	assign rem_s[0][1] = rem0_b;
	assign num_s[0][0] = num_a;
	assign num_s[0][1] = num_b;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [VW:0] t;
			logic [VW:0] diff;
			logic        ge;

			assign t    = {rem_s[i][l], num_s[i][l][QW-1]};
			assign diff = t - {1'b0, den_s[i]};
			assign ge   = t >= {1'b0, den_s[i]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1][l] <= ge ? diff[VW-1:0] : t[VW-1:0];
					num_s[i+1][l] <= {num_s[i][l][QW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				pay_s[i+1] <= pay_s[i];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo_a     = num_s[QW][0];
	assign quo_b     = num_s[QW][1];
	assign out_pay   = pay_s[QW];

endmodule

### rtl/core/kinematic_seek_flee_arrive_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    char_x, char_y, tgt_x, tgt_y
// rsp      out  valid/ready    vel_x, vel_y, arrived
// cfg      in   valid/ready    index, data (ready always high)
//
// One item enters per cycle unless the output stalls; the path runs through the
// offset length root (33 stages), the arrive divider (33 + FRAC_BITS stages),
// the arrive length root (33 stages) and the full-speed divider (31 stages).
// Reset clears the stage valid bits and loads the register defaults.
// A held result in the output stage freezes the whole pipeline; req.ready drops.
module kinematic_seek_flee_arrive_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ksfa_in_if.sink      req,
	ksfa_out_if.source   rsp,
	ksfa_cfg_if.sink     cfg
);
	import ksfa_pkg::*;

	localparam int MAG_W = POS_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int QA_W  = MAG_W + FRAC_BITS;
	localparam int PR_W  = MAG_W + SPD_W;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             nx;
		logic             ny;
	} p1_t;

	typedef struct packed {
		p1_t              p1;
		logic [MAG_W-1:0] off_len;
	} p2_t;

	typedef struct packed {
		p2_t              p2;
		logic [POS_W-1:0] qx;
		logic [POS_W-1:0] qy;
		logic             big;
	} p3_t;

	typedef struct packed {
		logic             nx;
		logic             ny;
		logic             full_nz;
		logic             stop;
		logic [POS_W-1:0] slow_x;
		logic [POS_W-1:0] slow_y;
	} p4_t;

	function automatic logic [POS_W-1:0] sat32(input logic neg, input logic [POS_W-1:0] mag);
		logic [POS_W-1:0] r;
		if (!neg) begin
			r = mag[POS_W-1] ? {1'b0, {(POS_W-1){1'b1}}} : mag;
		end else if (mag > {1'b1, {(POS_W-1){1'b0}}}) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = -mag;
		end
		return r;
	endfunction

	// configuration
	mode_t            mode_q;
	logic [SPD_W-1:0] max_speed_q;
	logic [SPD_W-1:0] stop_radius_q;
	logic [SPD_W-1:0] time_tgt_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_SEEK;
			max_speed_q   <= MAX_SPEED_RST;
			stop_radius_q <= STOP_RAD_RST;
			time_tgt_q    <= TIME_TGT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:      mode_q        <= mode_t'(cfg.data[1:0]);
				REG_MAX_SPEED: max_speed_q   <= cfg.data[SPD_W-1:0];
				REG_STOP_RAD:  stop_radius_q <= cfg.data[SPD_W-1:0];
				REG_TIME_TGT:  time_tgt_q    <= cfg.data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign en        = !v_s7 || rsp.ready;
	assign req.ready = en;

	// stage 1: offset and magnitudes
	logic signed [MAG_W-1:0] dx, dy;
	logic        [MAG_W-1:0] ax, ay;
	p1_t                     p1_s1;

	always_comb begin
		if (mode_q == MODE_FLEE) begin
			dx = {req.char_x[POS_W-1], req.char_x} - {req.tgt_x[POS_W-1], req.tgt_x};
			dy = {req.char_y[POS_W-1], req.char_y} - {req.tgt_y[POS_W-1], req.tgt_y};
		end else begin
			dx = {req.tgt_x[POS_W-1], req.tgt_x} - {req.char_x[POS_W-1], req.char_x};
			dy = {req.tgt_y[POS_W-1], req.tgt_y} - {req.char_y[POS_W-1], req.char_y};
		end
		ax = dx[MAG_W-1] ? -dx : dx;
		ay = dy[MAG_W-1] ? -dy : dy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1.ax <= ax;
			p1_s1.ay <= ay;
			p1_s1.nx <= dx[MAG_W-1];
			p1_s1.ny <= dy[MAG_W-1];
		end
	end

	// stage 2: squares
	logic [SQ_W-1:0] a2_s2, b2_s2;
	p1_t             p1_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s2 <= p1_s1.ax * p1_s1.ax;
			b2_s2 <= p1_s1.ay * p1_s1.ay;
			p1_s2 <= p1_s1;
		end
	end

	// stage 3: sum of squares
	logic [SQ_W-1:0] rad_s3;
	p1_t             p1_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= a2_s2 + b2_s2;
			p1_s3  <= p1_s2;
		end
	end

	logic             sq1_v;
	logic [MAG_W-1:0] off_len;
	logic [$bits(p1_t)-1:0] sq1_pay;

	ksfa_sqrt #(.RAD_W(SQ_W), .PAY_W($bits(p1_t))) u_len (
		.clk, .arst_n, .en,
		.in_valid (v_s3),
		.in_rad   (rad_s3),
		.in_pay   (p1_s3),
		.out_valid(sq1_v),
		.out_root (off_len),
		.out_pay  (sq1_pay)
	);

	// arrive speed: offset scaled by 1 / time_to_target
	p2_t              p2_in;
	logic [SPD_W-1:0] t_eff;
	logic             dva_v;
	logic [QA_W-1:0]  qa, qb;
	logic [$bits(p2_t)-1:0] dva_pay;
	p2_t              p2_out;

	assign p2_in.p1      = p1_t'(sq1_pay);
	assign p2_in.off_len = off_len;
	assign t_eff         = (time_tgt_q == '0) ? SPD_W'(1) : time_tgt_q;
	assign p2_out        = p2_t'(dva_pay);

	ksfa_div #(.VW(SPD_W), .QW(QA_W), .PAY_W($bits(p2_t))) u_div_arr (
		.clk, .arst_n, .en,
		.in_valid (sq1_v),
		.rem0_a   ('0),
		.rem0_b   ('0),
		.num_a    ({p2_in.p1.ax, {FRAC_BITS{1'b0}}}),
		.num_b    ({p2_in.p1.ay, {FRAC_BITS{1'b0}}}),
		.den      (t_eff),
		.in_pay   (p2_in),
		.out_valid(dva_v),
		.quo_a    (qa),
		.quo_b    (qb),
		.out_pay  (dva_pay)
	);

	// stage 4: range check and squares of the arrive velocity
	logic [2*POS_W-1:0] sqx_s4, sqy_s4;
	p3_t                p3_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4    <= qa[POS_W-1:0] * qa[POS_W-1:0];
			sqy_s4    <= qb[POS_W-1:0] * qb[POS_W-1:0];
			p3_s4.p2  <= p2_out;
			p3_s4.qx  <= qa[POS_W-1:0];
			p3_s4.qy  <= qb[POS_W-1:0];
			p3_s4.big <= (|qa[QA_W-1:POS_W]) || (|qb[QA_W-1:POS_W]);
		end
	end

	// stage 5: sum
	logic [SQ_W-1:0] rad_s5;
	p3_t             p3_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5 <= {2'b00, sqx_s4} + {2'b00, sqy_s4};
			p3_s5  <= p3_s4;
		end
	end

	logic             sq2_v;
	logic [MAG_W-1:0] len2;
	logic [$bits(p3_t)-1:0] sq2_pay;
	p3_t              p3_out;

	ksfa_sqrt #(.RAD_W(SQ_W), .PAY_W($bits(p3_t))) u_len_arr (
		.clk, .arst_n, .en,
		.in_valid (v_s5),
		.in_rad   (rad_s5),
		.in_pay   (p3_s5),
		.out_valid(sq2_v),
		.out_root (len2),
		.out_pay  (sq2_pay)
	);

	assign p3_out = p3_t'(sq2_pay);

	// stage 6: pick the path, form the full-speed numerators
	logic             stop, over, full, slow_ok;
	logic [PR_W-1:0]  prx_s6, pry_s6;
	logic [MAG_W-1:0] dist_s6;
	p4_t              p4_s6;

	always_comb begin
		stop    = (mode_q == MODE_ARRIVE) && (p3_out.p2.off_len < {2'b00, stop_radius_q});
		over    = p3_out.big || (len2 > {2'b00, max_speed_q});
		full    = (mode_q == MODE_SEEK) || (mode_q == MODE_FLEE) ||
		          ((mode_q == MODE_ARRIVE) && !stop && over);
		slow_ok = (mode_q == MODE_ARRIVE) && !stop && !over;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s6        <= p3_out.p2.p1.ax * max_speed_q;
			pry_s6        <= p3_out.p2.p1.ay * max_speed_q;
			dist_s6       <= p3_out.p2.off_len;
			p4_s6.nx      <= p3_out.p2.p1.nx;
			p4_s6.ny      <= p3_out.p2.p1.ny;
			p4_s6.full_nz <= full && (p3_out.p2.off_len != '0);
			p4_s6.stop    <= stop;
			p4_s6.slow_x  <= slow_ok ? sat32(p3_out.p2.p1.nx, p3_out.qx) : '0;
			p4_s6.slow_y  <= slow_ok ? sat32(p3_out.p2.p1.ny, p3_out.qy) : '0;
		end
	end

	// full speed: offset * max_speed / length, quotient never above max_speed
	logic             dvf_v;
	logic [SPD_W-1:0] fx, fy;
	logic [$bits(p4_t)-1:0] dvf_pay;
	p4_t              p4_out;

	ksfa_div #(.VW(MAG_W), .QW(SPD_W), .PAY_W($bits(p4_t))) u_div_full (
		.clk, .arst_n, .en,
		.in_valid (v_s6),
		.rem0_a   (prx_s6[PR_W-1:SPD_W]),
		.rem0_b   (pry_s6[PR_W-1:SPD_W]),
		.num_a    (prx_s6[SPD_W-1:0]),
		.num_b    (pry_s6[SPD_W-1:0]),
		.den      (dist_s6),
		.in_pay   (p4_s6),
		.out_valid(dvf_v),
		.quo_a    (fx),
		.quo_b    (fy),
		.out_pay  (dvf_pay)
	);

	assign p4_out = p4_t'(dvf_pay);

	// stage 7: output register
	logic [POS_W-1:0] vx_s7, vy_s7;
	logic             arr_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			if (p4_out.full_nz) begin
				vx_s7 <= p4_out.nx ? -{1'b0, fx} : {1'b0, fx};
				vy_s7 <= p4_out.ny ? -{1'b0, fy} : {1'b0, fy};
			end else begin
				vx_s7 <= p4_out.slow_x;
				vy_s7 <= p4_out.slow_y;
			end
			arr_s7 <= p4_out.stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dva_v;
			v_s5 <= v_s4;
			v_s6 <= sq2_v;
			v_s7 <= dvf_v;
		end
	end

	assign rsp.valid   = v_s7;
	assign rsp.vel_x   = vx_s7;
	assign rsp.vel_y   = vy_s7;
	assign rsp.arrived = arr_s7;

	a_arrived_still: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.arrived |-> rsp.vel_x == '0 && rsp.vel_y == '0)
		else $error("arrived item carries a nonzero velocity");

	a_arrived_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && mode_q != MODE_ARRIVE |-> !rsp.arrived)
		else $error("arrived flag outside arrive mode");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s6) && $stable(dist_s6))
		else $error("pipeline moved during a stall");

endmodule
